/* rtl/bdp_pkg.sv */
// ----------------------------------------------------------------------------
// bdp_pkg
// Shared constants, register codes and types of the block delta pixel
// predictor.
// ----------------------------------------------------------------------------
package bdp_pkg;

    // default sizes of the line buffer and the largest tile side
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_TILE_DEF  = 256;

    // byte channels per pixel, one lane each
    localparam int LANES  = 3;
    localparam int CHAN_W = 8;
    localparam int PIX_W  = LANES * CHAN_W;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THREE_CHANNELS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_WIDTH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd4;

    localparam int BLOCK_WIDTH_W  = 9;
    localparam int IMAGE_WIDTH_W  = 13;
    localparam int IMAGE_HEIGHT_W = 16;

    localparam logic [BLOCK_WIDTH_W-1:0]  BLOCK_WIDTH_RST  = 9'd64;
    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 13'd1024;
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 16'd1024;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // result fields
    localparam int TILE_INDEX_W  = 24;
    localparam int TILE_OFFSET_W = 16;
    localparam int TILE_COL_WRAP = 12;

    // position of the current pixel, as seen by the datapath
    typedef struct packed {
        logic                     in_tile;
        logic                     origin;
        logic                     first_row;
        logic [TILE_INDEX_W-1:0]  tile_index;
        logic [TILE_OFFSET_W-1:0] tile_offset;
    } pos_t;

endpackage

/* rtl/bdp_ram.sv */
// ----------------------------------------------------------------------------
// bdp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bdp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bdp_lane.sv */
// ----------------------------------------------------------------------------
// bdp_lane
// One byte channel: residual or rebuilt value from input and prediction.
// ----------------------------------------------------------------------------
module bdp_lane (
    input  logic                      direction,
    input  logic                      origin,
    input  logic [bdp_pkg::CHAN_W-1:0] value,
    input  logic [bdp_pkg::CHAN_W-1:0] pred,
    output logic [bdp_pkg::CHAN_W-1:0] result
);

    always_comb
    begin
        if (origin)
        begin
            result = value;
        end
        else if (direction == bdp_pkg::DIR_DECODE)
        begin
            result = value + pred;
        end
        else
        begin
            result = value - pred;
        end
    end

endmodule

/* rtl/bdp_position.sv */
// ----------------------------------------------------------------------------
// bdp_position
// Raster position tracker: column, row, place in tile and tile index.
// ----------------------------------------------------------------------------
module bdp_position #(
    parameter int MAX_WIDTH = bdp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_TILE  = bdp_pkg::MAX_TILE_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 restart,
    input  logic [$clog2(MAX_TILE):0]            bw,
    input  logic [$clog2(MAX_WIDTH):0]           w,
    input  logic [bdp_pkg::IMAGE_HEIGHT_W-1:0]   h,
    output logic [$clog2(MAX_WIDTH)-1:0]         slot,
    output bdp_pkg::pos_t                        pos
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int TW  = $clog2(MAX_TILE);
    localparam int BWW = TW + 1;
    localparam int TCW = (CW > bdp_pkg::TILE_COL_WRAP) ? CW : bdp_pkg::TILE_COL_WRAP;
    localparam int EW  = ((CW > BWW) ? CW : BWW) + 1;
    localparam int PW  = TW + BWW;
    localparam int HW  = bdp_pkg::IMAGE_HEIGHT_W;
    localparam int XW  = bdp_pkg::TILE_INDEX_W;

    logic [CW-1:0]  column_count_reg, column_count_next;
    logic [HW-1:0]  row_count_reg, row_count_next;
    logic [TW-1:0]  column_in_tile_reg, column_in_tile_next;
    logic [TW-1:0]  row_in_tile_reg, row_in_tile_next;
    logic [TCW-1:0] tile_column_reg, tile_column_next;
    logic [XW-1:0]  tile_row_base_reg, tile_row_base_next;

    logic [CW-1:0]  col_start;
    logic [HW-1:0]  row_start;
    logic           inside_col;
    logic           inside_row;
    logic           col_last;
    logic           row_last;
    logic           cit_last;
    logic           rit_last;
    logic [TCW-1:0] tiles_per_row;

    // a pixel is inside when its whole tile fits in the image
    assign col_start  = column_count_reg - CW'(column_in_tile_reg);
    assign row_start  = row_count_reg - HW'(row_in_tile_reg);
    assign inside_col = (EW'(col_start) + EW'(bw)) <= EW'(w);
    assign inside_row = ((HW+1)'(row_start) + (HW+1)'(bw)) <= (HW+1)'(h);

    assign col_last = ((CW+1)'(column_count_reg) + (CW+1)'(1)) >= w;
    assign row_last = ((HW+1)'(row_count_reg) + (HW+1)'(1)) >= (HW+1)'(h);
    assign cit_last = (BWW'(column_in_tile_reg) + BWW'(1)) >= bw;
    assign rit_last = (BWW'(row_in_tile_reg) + BWW'(1)) >= bw;

    // tiles finished in this row, known at its last pixel
    assign tiles_per_row = tile_column_reg + TCW'(cit_last);

    assign slot = column_count_reg;

    always_comb
    begin
        pos.in_tile     = inside_col && inside_row;
        pos.origin      = (column_in_tile_reg == '0) && (row_in_tile_reg == '0);
        pos.first_row   = (row_in_tile_reg == '0);
        pos.tile_index  = tile_row_base_reg
                        + XW'(tile_column_reg[bdp_pkg::TILE_COL_WRAP-1:0]);
        pos.tile_offset = bdp_pkg::TILE_OFFSET_W'(PW'(row_in_tile_reg) * PW'(bw)
                                                 + PW'(column_in_tile_reg));
    end

    always_comb
    begin
        column_count_next   = column_count_reg;
        row_count_next      = row_count_reg;
        column_in_tile_next = column_in_tile_reg;
        row_in_tile_next    = row_in_tile_reg;
        tile_column_next    = tile_column_reg;
        tile_row_base_next  = tile_row_base_reg;
        if (restart)
        begin
            column_count_next   = '0;
            row_count_next      = '0;
            column_in_tile_next = '0;
            row_in_tile_next    = '0;
            tile_column_next    = '0;
            tile_row_base_next  = '0;
        end
        else if (advance)
        begin
            if (col_last)
            begin
                column_count_next   = '0;
                column_in_tile_next = '0;
                tile_column_next    = '0;
                if (row_last)
                begin
                    row_count_next     = '0;
                    row_in_tile_next   = '0;
                    tile_row_base_next = '0;
                end
                else
                begin
                    row_count_next = row_count_reg + HW'(1);
                    if (rit_last)
                    begin
                        row_in_tile_next   = '0;
                        tile_row_base_next = tile_row_base_reg + XW'(tiles_per_row);
                    end
                    else
                    begin
                        row_in_tile_next = row_in_tile_reg + TW'(1);
                    end
                end
            end
            else
            begin
                column_count_next = column_count_reg + CW'(1);
                if (cit_last)
                begin
                    column_in_tile_next = '0;
                    tile_column_next    = tile_column_reg + TCW'(1);
                end
                else
                begin
                    column_in_tile_next = column_in_tile_reg + TW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg   <= '0;
            row_count_reg      <= '0;
            column_in_tile_reg <= '0;
            row_in_tile_reg    <= '0;
            tile_column_reg    <= '0;
            tile_row_base_reg  <= '0;
        end
        else
        begin
            column_count_reg   <= column_count_next;
            row_count_reg      <= row_count_next;
            column_in_tile_reg <= column_in_tile_next;
            row_in_tile_reg    <= row_in_tile_next;
            tile_column_reg    <= tile_column_next;
            tile_row_base_reg  <= tile_row_base_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        BWW'(column_in_tile_reg) < bw && BWW'(row_in_tile_reg) < bw)
        else $error("place in tile beyond tile side");

    assert property (@(posedge clk) disable iff (!rst_n)
        (CW+1)'(column_count_reg) < w)
        else $error("column beyond image width");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !restart && col_last) |=> (column_count_reg == '0))
        else $error("row end did not return to column zero");

endmodule

/* rtl/block_delta_pixel_predictor.sv */
// ----------------------------------------------------------------------------
// block_delta_pixel_predictor
// Tiled left / above DPCM predictor for one or three byte channels, with a
// one-row line buffer, encode and decode directions.
// ----------------------------------------------------------------------------
//  channel   signals                        content
//  s_*       s_tvalid s_tready s_tdata[23:0] input pixel or residual item
//  m_*       m_tvalid m_tready m_tdata[63:0] result item, m_tuser is_origin
//  cfg_*     cfg_we cfg_index cfg_data       register write, no read-back
//
//  one item per clock sustained while the output is not stalled; an item passes
//  from input to output register through the compute stage: line buffer read,
//  then lane arithmetic and the left-pixel feedback that sets the recurrence.
//  rst_n clears control and configuration; the line buffer is not cleared.
//  a stalled output holds the compute stage, which then holds s_tready low.
//  items outside whole tiles pass through and update state with no result.
// ----------------------------------------------------------------------------
module block_delta_pixel_predictor #(
    parameter int MAX_WIDTH = bdp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_TILE  = bdp_pkg::MAX_TILE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // value_a [7:0], value_b [15:8], value_c [23:16]
    input  logic [23:0]                        s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_a [7:0], out_b [15:8], out_c [23:16], tile_index [47:24],
    // tile_offset [63:48]
    output logic [63:0]                        m_tdata,
    // is_origin [0]
    output logic [0:0]                         m_tuser,
    input  logic                               cfg_we,
    input  logic [bdp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bdp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int TW  = $clog2(MAX_TILE);
    localparam int BWW = TW + 1;
    localparam int PXW = bdp_pkg::PIX_W;
    localparam int CHW = bdp_pkg::CHAN_W;

    // configuration
    logic                                 direction_reg;
    logic                                 three_channels_reg;
    logic [bdp_pkg::BLOCK_WIDTH_W-1:0]    block_width_reg;
    logic [bdp_pkg::IMAGE_WIDTH_W-1:0]    image_width_reg;
    logic [bdp_pkg::IMAGE_HEIGHT_W-1:0]   image_height_reg;
    logic                                 restart;

    logic [BWW-1:0]                       bw;
    logic [CW:0]                          w;
    logic [bdp_pkg::IMAGE_HEIGHT_W-1:0]   h;
    logic [PXW-1:0]                       chan_mask;

    // input side
    logic                                 accept;
    logic [CW-1:0]                        slot;
    bdp_pkg::pos_t                        pos;

    // compute stage
    logic                                 s1_valid_reg, s1_valid_next;
    logic                                 s1_fwd_reg;
    logic [PXW-1:0]                       s1_px_reg;
    logic [CW-1:0]                        s1_addr_reg;
    bdp_pkg::pos_t                        s1_pos_reg;
    logic                                 s1_go;
    logic [PXW-1:0]                       above;
    logic [PXW-1:0]                       pred;
    logic [PXW-1:0]                       lane_res;
    logic [PXW-1:0]                       res;
    logic [PXW-1:0]                       pixel;
    logic [PXW-1:0]                       left_pixel_reg, left_pixel_next;

    // output register
    logic                                 out_valid_reg, out_valid_next;
    logic [63:0]                          out_data_reg;
    logic                                 out_user_reg;

    // ---------------- configuration ----------------
    assign restart = cfg_we && (cfg_index == bdp_pkg::CFG_DIRECTION
                             || cfg_index == bdp_pkg::CFG_THREE_CHANNELS
                             || cfg_index == bdp_pkg::CFG_BLOCK_WIDTH
                             || cfg_index == bdp_pkg::CFG_IMAGE_WIDTH
                             || cfg_index == bdp_pkg::CFG_IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg      <= bdp_pkg::DIR_ENCODE;
            three_channels_reg <= 1'b1;
            block_width_reg    <= bdp_pkg::BLOCK_WIDTH_RST;
            image_width_reg    <= bdp_pkg::IMAGE_WIDTH_RST;
            image_height_reg   <= bdp_pkg::IMAGE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdp_pkg::CFG_DIRECTION:      direction_reg      <= cfg_data[0];
                bdp_pkg::CFG_THREE_CHANNELS: three_channels_reg <= cfg_data[0];
                bdp_pkg::CFG_BLOCK_WIDTH:
                    block_width_reg  <= cfg_data[bdp_pkg::BLOCK_WIDTH_W-1:0];
                bdp_pkg::CFG_IMAGE_WIDTH:
                    image_width_reg  <= cfg_data[bdp_pkg::IMAGE_WIDTH_W-1:0];
                bdp_pkg::CFG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_data[bdp_pkg::IMAGE_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped working values
    always_comb
    begin
        if (block_width_reg < 9'd2)
        begin
            bw = BWW'(2);
        end
        else if (32'(block_width_reg) > 32'(MAX_TILE))
        begin
            bw = BWW'(MAX_TILE);
        end
        else
        begin
            bw = BWW'(block_width_reg);
        end

        if (image_width_reg == '0)
        begin
            w = (CW+1)'(1);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            w = (CW+1)'(MAX_WIDTH);
        end
        else
        begin
            w = (CW+1)'(image_width_reg);
        end

        h = (image_height_reg == '0) ? bdp_pkg::IMAGE_HEIGHT_W'(1) : image_height_reg;
    end

    assign chan_mask = three_channels_reg ? {PXW{1'b1}} : PXW'({CHW{1'b1}});

    // ---------------- input stage ----------------
    assign s1_go    = s1_valid_reg && (!s1_pos_reg.in_tile || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign accept   = s_tvalid && s_tready;

    bdp_position #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TILE  (MAX_TILE)
    ) u_position (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .restart (restart),
        .bw      (bw),
        .w       (w),
        .h       (h),
        .slot    (slot),
        .pos     (pos)
    );

    bdp_ram #(
        .WIDTH (PXW),
        .DEPTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_addr_reg),
        .wdata (pixel),
        .re    (accept),
        .raddr (slot),
        .rdata (above)
    );

    assign s1_valid_next = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                // same-slot write on this edge is missed by the read
                s1_fwd_reg <= s1_go && (s1_addr_reg == slot);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= s_tdata & chan_mask;
            s1_addr_reg <= slot;
            s1_pos_reg  <= pos;
        end
    end

    // ---------------- compute stage: lanes and merge ----------------
    assign pred = (s1_pos_reg.first_row || s1_fwd_reg) ? left_pixel_reg : above;

    for (genvar k = 0; k < bdp_pkg::LANES; k++)
    begin : g_lane
        bdp_lane u_lane (
            .direction (direction_reg),
            .origin    (s1_pos_reg.origin),
            .value     (s1_px_reg[k*CHW +: CHW]),
            .pred      (pred[k*CHW +: CHW]),
            .result    (lane_res[k*CHW +: CHW])
        );
    end

    assign res   = lane_res & chan_mask;
    // pixels outside whole tiles keep their input value in both directions
    assign pixel = (direction_reg == bdp_pkg::DIR_DECODE && s1_pos_reg.in_tile)
                 ? res : s1_px_reg;

    always_comb
    begin
        left_pixel_next = left_pixel_reg;
        if (restart)
        begin
            left_pixel_next = '0;
        end
        else if (s1_go)
        begin
            left_pixel_next = pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_pixel_reg <= '0;
        end
        else
        begin
            left_pixel_reg <= left_pixel_next;
        end
    end

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && s1_pos_reg.in_tile)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_pos_reg.in_tile)
        begin
            out_data_reg <= {s1_pos_reg.tile_offset, s1_pos_reg.tile_index, res};
            out_user_reg <= s1_pos_reg.origin;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;

    // ---------------- checks ----------------
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item did not reach the compute stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_pos_reg.in_tile) |=> m_tvalid)
        else $error("tile pixel left the compute stage with no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_pos_reg.origin) |-> (s1_pos_reg.tile_offset == '0))
        else $error("tile origin with nonzero offset");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("held compute stage item changed");

endmodule

/* bench/block_delta_pixel_predictor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_delta_pixel_predictor_tb
// Self-checking bench for the tiled left / above pixel predictor. Pixels are
// streamed in through a queue-fed driver, a monitor mirrors the predictor
// state for every accepted item and checks each result item in order. Runs
// short directed images, then random configurations and images, then the
// size extremes, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module block_delta_pixel_predictor_tb;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 120;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 400;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // no register lives at this index, a write must leave the position alone
    localparam logic [bdp_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    // byte extremes, picked by 8-bit slices
    localparam logic [47:0] EDGE_BYTES = 48'hFE7F_8001_FF00;

    typedef struct packed {
        logic [7:0]                        out_a;
        logic [7:0]                        out_b;
        logic [7:0]                        out_c;
        logic                              origin;
        logic [bdp_pkg::TILE_INDEX_W-1:0]  tile_index;
        logic [bdp_pkg::TILE_OFFSET_W-1:0] tile_offset;
    } tile_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [23:0]                     s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [63:0]                     m_tdata;
    logic [0:0]                      m_tuser;
    logic                            cfg_we = 1'b0;
    logic [bdp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bdp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    logic [23:0]  pixel_feed_q[$];
    tile_result_t tile_result_q[$];

    bit feed_taken = 1'b0;
    bit idle_on = 1'b0;
    bit long_hold_req = 1'b0;
    int src_gap = 0;
    int sink_gap = 0;
    int hold_left = 0;
    int fail_count = 0;
    int cycle_count = 0;

    // mirrored configuration
    logic        cfg_dir = bdp_pkg::DIR_ENCODE;
    logic        cfg_three = 1'b1;
    int unsigned cfg_block = bdp_pkg::BLOCK_WIDTH_RST;
    int unsigned cfg_width = bdp_pkg::IMAGE_WIDTH_RST;
    int unsigned cfg_height = bdp_pkg::IMAGE_HEIGHT_RST;

    // mirrored position and pixel history
    logic [23:0] line_buf [bdp_pkg::MAX_WIDTH_DEF];
    logic [23:0] left_pix = '0;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    int unsigned tile_col_pos = 0;
    int unsigned tile_row_pos = 0;
    int unsigned tile_x = 0;
    int unsigned tile_row_first = 0;

    block_delta_pixel_predictor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL block_delta_pixel_predictor");
            $finish;
        end
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic apply_register(input logic [bdp_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [bdp_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            bdp_pkg::CFG_DIRECTION:      cfg_dir = data[0];
            bdp_pkg::CFG_THREE_CHANNELS: cfg_three = data[0];
            bdp_pkg::CFG_BLOCK_WIDTH:
                cfg_block = 32'(data[bdp_pkg::BLOCK_WIDTH_W-1:0]);
            bdp_pkg::CFG_IMAGE_WIDTH:
                cfg_width = 32'(data[bdp_pkg::IMAGE_WIDTH_W-1:0]);
            bdp_pkg::CFG_IMAGE_HEIGHT:
                cfg_height = 32'(data[bdp_pkg::IMAGE_HEIGHT_W-1:0]);
            default: ;
        endcase
        if (idx <= bdp_pkg::CFG_IMAGE_HEIGHT)
        begin
            left_pix = '0;
            col_pos = 0;
            row_pos = 0;
            tile_col_pos = 0;
            tile_row_pos = 0;
            tile_x = 0;
            tile_row_first = 0;
        end
    endtask

    task automatic predict_tile_result(input logic [23:0] raw);
        int unsigned  side, width, height, tiles_across, tile_rows, slot, k;
        logic [23:0]  lane_mask, px, pred, res, pixel;
        logic [7:0]   lane_in, lane_pred, lane_out;
        tile_result_t r;
        side = (cfg_block < 2) ? 2
             : ((cfg_block > bdp_pkg::MAX_TILE_DEF) ? bdp_pkg::MAX_TILE_DEF : cfg_block);
        width = (cfg_width < 1) ? 1
              : ((cfg_width > bdp_pkg::MAX_WIDTH_DEF) ? bdp_pkg::MAX_WIDTH_DEF : cfg_width);
        height = (cfg_height < 1) ? 1 : cfg_height;
        tiles_across = width / side;
        tile_rows = height / side;
        lane_mask = cfg_three ? 24'hFFFFFF : 24'h0000FF;
        px = raw & lane_mask;
        slot = col_pos % bdp_pkg::MAX_WIDTH_DEF;
        pixel = px;
        res = '0;
        if (col_pos < tiles_across * side && row_pos < tile_rows * side)
        begin
            r.origin = (tile_col_pos == 0) && (tile_row_pos == 0);
            // first row of each tile predicts from the left, later rows from above
            pred = (tile_row_pos == 0) ? left_pix : line_buf[slot];
            for (k = 0; k < 3; k++)
            begin
                lane_in = px[8*k +: 8];
                lane_pred = pred[8*k +: 8];
                if (r.origin)
                    lane_out = lane_in;
                else if (cfg_dir == bdp_pkg::DIR_DECODE)
                    lane_out = lane_in + lane_pred;
                else
                    lane_out = lane_in - lane_pred;
                res[8*k +: 8] = lane_out;
            end
            res = res & lane_mask;
            if (cfg_dir == bdp_pkg::DIR_DECODE)
                pixel = res;
            r.out_a = res[7:0];
            r.out_b = res[15:8];
            r.out_c = res[23:16];
            r.tile_index = bdp_pkg::TILE_INDEX_W'(tile_row_first + tile_x);
            r.tile_offset = bdp_pkg::TILE_OFFSET_W'(tile_row_pos * side + tile_col_pos);
            tile_result_q = {tile_result_q, r};
        end
        line_buf[slot] = pixel;
        left_pix = pixel;
        if (col_pos + 1 >= width)
        begin
            col_pos = 0;
            tile_col_pos = 0;
            tile_x = 0;
            if (row_pos + 1 >= height)
            begin
                row_pos = 0;
                tile_row_pos = 0;
                tile_row_first = 0;
            end
            else
            begin
                row_pos++;
                if (tile_row_pos + 1 >= side)
                begin
                    tile_row_pos = 0;
                    tile_row_first = (tile_row_first + tiles_across) & 32'hFF_FFFF;
                end
                else
                    tile_row_pos++;
            end
        end
        else
        begin
            col_pos++;
            if (tile_col_pos + 1 >= side)
            begin
                tile_col_pos = 0;
                tile_x = (tile_x + 1) & 32'hFFF;
            end
            else
                tile_col_pos++;
        end
    endtask

    // checks the outgoing item first, then mirrors register writes and inputs
    always @(posedge clk)
    begin : monitor
        tile_result_t want, got;
        feed_taken = rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser[0],
                       m_tdata[47:24], m_tdata[63:48]};
                if (tile_result_q.size() == 0)
                    note_failure($sformatf("unexpected result item %h user %b",
                                           m_tdata, m_tuser));
                else
                begin
                    want = tile_result_q.pop_front();
                    if (got.out_a !== want.out_a || got.out_b !== want.out_b ||
                        got.out_c !== want.out_c || got.origin !== want.origin ||
                        got.tile_index !== want.tile_index ||
                        got.tile_offset !== want.tile_offset)
                        note_failure($sformatf(
                            "mismatch: exp %h %h %h %b %0d %0d, got %h %h %h %b %0d %0d",
                            want.out_a, want.out_b, want.out_c, want.origin,
                            want.tile_index, want.tile_offset,
                            got.out_a, got.out_b, got.out_c, got.origin,
                            got.tile_index, got.tile_offset));
                end
            end
            if (cfg_we)
                apply_register(cfg_index, cfg_data);
            if (feed_taken)
                predict_tile_result(s_tdata);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || feed_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pixel_feed_q.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pixel_feed_q.pop_front();
                if (idle_on && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 12);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // long receiver hold, counted in cycles
    always @(posedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        else if (hold_left > 0)
            hold_left--;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
                m_tready <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 12);
            end
        end
    end

    function automatic logic [23:0] random_pixel();
        logic [23:0] px;
        int unsigned k;
        px = 24'($urandom);
        for (k = 0; k < 3; k++)
            if ($urandom_range(0, 7) == 0)
                px[8*k +: 8] = EDGE_BYTES[8*$urandom_range(0, 5) +: 8];
        return px;
    endfunction

    // upper data bits beyond the register width are sometimes set as noise
    task automatic write_register(input logic [bdp_pkg::CFG_INDEX_W-1:0] idx,
                                  input int unsigned value, input int unsigned width);
        logic [bdp_pkg::CFG_DATA_W-1:0] keep, data;
        keep = bdp_pkg::CFG_DATA_W'((32'h1 << width) - 1);
        data = bdp_pkg::CFG_DATA_W'(value) & keep;
        if ($urandom_range(0, 3) == 0)
            data = data | (bdp_pkg::CFG_DATA_W'($urandom) & ~keep);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_items(input int unsigned count, input bit directed);
        int unsigned i;
        @(posedge clk);
        for (i = 0; i < count; i++)
            if (directed)
                pixel_feed_q = {pixel_feed_q, {EDGE_BYTES[8*((i + 2) % 6) +: 8],
                                               EDGE_BYTES[8*((i + 1) % 6) +: 8],
                                               EDGE_BYTES[8*(i % 6) +: 8]}};
            else
                pixel_feed_q = {pixel_feed_q, random_pixel()};
    endtask

    task automatic drain_all();
        while (pixel_feed_q.size() != 0 || s_tvalid || tile_result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic dir, input logic three,
                             input int unsigned side, input int unsigned width,
                             input int unsigned height, input int unsigned count,
                             input bit directed, input bit idle);
        idle_on = idle;
        write_register(bdp_pkg::CFG_DIRECTION, dir, 1);
        write_register(bdp_pkg::CFG_THREE_CHANNELS, three, 1);
        write_register(bdp_pkg::CFG_BLOCK_WIDTH, side, bdp_pkg::BLOCK_WIDTH_W);
        write_register(bdp_pkg::CFG_IMAGE_WIDTH, width, bdp_pkg::IMAGE_WIDTH_W);
        write_register(bdp_pkg::CFG_IMAGE_HEIGHT, height, bdp_pkg::IMAGE_HEIGHT_W);
        push_items(count, directed);
        drain_all();
    endtask

    initial
    begin
        int unsigned random_total, side, width, height, count, eff_side, eff_w, eff_h;
        logic        dir;
        random_total = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // reset configuration: tile origin then first-row left deltas
        push_items(4, 1'b1);
        drain_all();
        // full image with outside column and outside row, then the next image
        run_phase(bdp_pkg::DIR_ENCODE, 1'b1, 2, 5, 3, 20, 1'b1, 1'b1);
        // one channel decode, image exactly one tile, twice
        run_phase(bdp_pkg::DIR_DECODE, 1'b0, 2, 2, 2, 8, 1'b1, 1'b1);
        // image narrower than a tile gives nothing
        run_phase(bdp_pkg::DIR_ENCODE, 1'b1, 4, 3, 8, 3, 1'b1, 1'b0);
        // write to an unused index mid-image, position carries on
        run_phase(bdp_pkg::DIR_DECODE, 1'b1, 3, 7, 6, 20, 1'b0, 1'b1);
        write_register(CFG_SPARE_INDEX, $urandom, bdp_pkg::CFG_DATA_W);
        push_items(30, 1'b0);
        drain_all();

        while (random_total < RANDOM_ITEMS)
        begin
            side = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
            eff_side = (side < 2) ? 2 : side;
            width = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 1)
                                                 : $urandom_range(1, 4 * eff_side + 3);
            height = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 1)
                                                  : $urandom_range(1, 4 * eff_side + 3);
            eff_w = (width == 0) ? 1 : width;
            eff_h = (height == 0) ? 1 : height;
            if (eff_w * eff_h <= 120 && $urandom_range(0, 3) != 0)
                count = eff_w * eff_h * $urandom_range(1, 2) + $urandom_range(0, 2);
            else
                count = $urandom_range(10, 150);
            dir = $urandom_range(0, 1) ? bdp_pkg::DIR_DECODE : bdp_pkg::DIR_ENCODE;
            run_phase(dir, 1'($urandom_range(0, 1)), side, width, height, count,
                      1'b0, $urandom_range(0, 4) != 0);
            random_total += count;
        end

        // widest tile, tallest image, output held off while input keeps coming
        long_hold_req = 1'b1;
        run_phase(bdp_pkg::DIR_ENCODE, 1'b1, 256, 512, 65535, 512 + 100, 1'b0, 1'b1);
        // tile side above the limit, clamped
        run_phase(bdp_pkg::DIR_DECODE, 1'b0, 300, 256, 256, 300, 1'b0, 1'b1);
        // image width above the limit, clamped
        run_phase(bdp_pkg::DIR_DECODE, 1'b0, 2, 8191, 2, 60, 1'b0, 1'b1);
        // single pixel images, side below the minimum
        run_phase(bdp_pkg::DIR_ENCODE, 1'b1, 1, 1, 1, 6, 1'b1, 1'b1);
        run_phase(bdp_pkg::DIR_DECODE, 1'b1, 0, 0, 0, 5, 1'b0, 1'b1);
        // closing stretch without idling
        run_phase(bdp_pkg::DIR_DECODE, 1'b1, 4, 13, 9, 220, 1'b0, 1'b0);

        if (fail_count == 0 && tile_result_q.size() == 0)
            $display("PASS block_delta_pixel_predictor");
        else
            $display("FAIL block_delta_pixel_predictor");
        $finish;
    end

endmodule

/* sim.f */
rtl/bdp_pkg.sv
rtl/bdp_ram.sv
rtl/bdp_lane.sv
rtl/bdp_position.sv
rtl/block_delta_pixel_predictor.sv
bench/block_delta_pixel_predictor_tb.sv
